// ===== src/artc_pkg.sv =====
// Shared types, constants and the saturation helper for the angular rate
// torque controller. No dependencies; every other file but artc_stream_if imports it.
`default_nettype none

package artc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int AXES          = 3;
  localparam int Q_W           = 32;
  localparam int GAIN_W        = 31;
  // wide enough for the sum of five 64-bit products
  localparam int SAT_W         = 68;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [GAIN_W-1:0]     ureg_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_RATE_GAIN  = 3'd0,
    REG_INERTIA_XX = 3'd1,
    REG_INERTIA_YY = 3'd2,
    REG_INERTIA_ZZ = 3'd3,
    REG_INERTIA_XY = 3'd4,
    REG_INERTIA_XZ = 3'd5,
    REG_INERTIA_YZ = 3'd6
  } cfg_reg_t;

  localparam int CFG_REG_COUNT = 7;

  typedef struct packed {
    q_t rate_x;
    q_t rate_y;
    q_t rate_z;
    q_t ref_rate_x;
    q_t ref_rate_y;
    q_t ref_rate_z;
    q_t ref_accel_x;
    q_t ref_accel_y;
    q_t ref_accel_z;
  } in_payload_t;

  typedef struct packed {
    q_t   torque_x;
    q_t   torque_y;
    q_t   torque_z;
    logic clipped;
  } out_payload_t;

  typedef struct packed {
    logic [2:0]     index;
    logic [Q_W-1:0] data;
  } cfg_payload_t;

  // per-stage load enables handed to every lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } lane_en_t;

  typedef struct packed {
    logic clip;
    q_t   val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t r;
    r.clip = !((&v[SAT_W-1:Q_W-1]) || !(|v[SAT_W-1:Q_W-1]));
    if (r.clip) begin
      r.val = v[SAT_W-1] ? Q_MIN : Q_MAX;
    end else begin
      r.val = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/artc_stream_if.sv =====
// Valid/ready channel carrying one payload beat.
// Payload type is a parameter; the types come from artc_pkg.
`default_nettype none

interface artc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/angular_rate_torque_controller_core.sv =====
// Angular rate torque controller (computed-torque law), top level.
// Depends on artc_pkg, artc_stream_if, artc_lane and artc_merge.
//
// Channels:
//   in_ch  - one beat carries measured rates, reference rates and reference
//            rate derivatives for x, y, z (Q16.16 signed).
//   out_ch - one beat per input beat: torque x, y, z (saturated) and clipped.
//   cfg_ch - register writes (index, data); always ready. Index 0 is the rate
//            gain, 1..3 the inertia diagonal, 4..6 the cross terms xy, xz, yz.
//            Indexes beyond 6 are ignored. Write only while the block is idle.
// Pipeline: a result passes three lane stages, the lane torque stage and the
//   output register after its input beat is accepted.
// Throughput: one beat per cycle while out_ch is not held; the three axis lanes
//   run side by side and every multiply sits alone between two registers.
// Reset: synchronous, active low. Clears the pipeline and loads the register
//   defaults (gain 0, identity inertia).
// Stall: when out_ch is held, stages keep filling until all bubbles are
//   squeezed out, then in_ch.ready drops. No beat is lost or repeated.
`default_nettype none

module angular_rate_torque_controller_core #(
  parameter int FRAC_BITS = artc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  artc_stream_if.sink   in_ch,
  artc_stream_if.source out_ch,
  artc_stream_if.sink   cfg_ch
);
  import artc_pkg::*;

  // configuration registers
  ureg_t rate_gain_r, inertia_xx_r, inertia_yy_r, inertia_zz_r;
  q_t    inertia_xy_r, inertia_xz_r, inertia_yz_r;
  logic  cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_gain_r  <= '0;
      inertia_xx_r <= GAIN_W'(1) << FRAC_BITS;
      inertia_yy_r <= GAIN_W'(1) << FRAC_BITS;
      inertia_zz_r <= GAIN_W'(1) << FRAC_BITS;
      inertia_xy_r <= '0;
      inertia_xz_r <= '0;
      inertia_yz_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_ch.payload.index)
        REG_RATE_GAIN:  rate_gain_r  <= cfg_ch.payload.data[GAIN_W-1:0];
        REG_INERTIA_XX: inertia_xx_r <= cfg_ch.payload.data[GAIN_W-1:0];
        REG_INERTIA_YY: inertia_yy_r <= cfg_ch.payload.data[GAIN_W-1:0];
        REG_INERTIA_ZZ: inertia_zz_r <= cfg_ch.payload.data[GAIN_W-1:0];
        REG_INERTIA_XY: inertia_xy_r <= cfg_ch.payload.data;
        REG_INERTIA_XZ: inertia_xz_r <= cfg_ch.payload.data;
        REG_INERTIA_YZ: inertia_yz_r <= cfg_ch.payload.data;
        default: ;
      endcase
    end
  end

  // symmetric inertia tensor
  q_t j_mat [AXES][AXES];

  assign j_mat[0][0] = q_t'({1'b0, inertia_xx_r});
  assign j_mat[1][1] = q_t'({1'b0, inertia_yy_r});
  assign j_mat[2][2] = q_t'({1'b0, inertia_zz_r});
  assign j_mat[0][1] = inertia_xy_r;
  assign j_mat[1][0] = inertia_xy_r;
  assign j_mat[0][2] = inertia_xz_r;
  assign j_mat[2][0] = inertia_xz_r;
  assign j_mat[1][2] = inertia_yz_r;
  assign j_mat[2][1] = inertia_yz_r;

  // pipeline control, bubbles collapse stage by stage
  logic     v1_r, v2_r, v3_r, v4_r;
  logic     v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic     en1, en2, en3, en4;
  logic     mrg_ready;
  lane_en_t lane_en;

  assign en4 = !v4_r || mrg_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;

  assign v1_nxt = en1 ? in_ch.valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;
  assign v4_nxt = en4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign lane_en = '{s1: en1, s2: en2, s3: en3, s4: en4};

  // lane wiring
  q_t         w_vec  [AXES];
  q_t         rr_vec [AXES];
  q_t         ra_vec [AXES];
  q_t         a_vec  [AXES];
  q_t         h_vec  [AXES];
  q_t         tq_vec [AXES];
  logic [2:0] clip_vec;

  assign w_vec[0]  = in_ch.payload.rate_x;
  assign w_vec[1]  = in_ch.payload.rate_y;
  assign w_vec[2]  = in_ch.payload.rate_z;
  assign rr_vec[0] = in_ch.payload.ref_rate_x;
  assign rr_vec[1] = in_ch.payload.ref_rate_y;
  assign rr_vec[2] = in_ch.payload.ref_rate_z;
  assign ra_vec[0] = in_ch.payload.ref_accel_x;
  assign ra_vec[1] = in_ch.payload.ref_accel_y;
  assign ra_vec[2] = in_ch.payload.ref_accel_z;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    localparam int K1 = (g + 1) % AXES;
    localparam int K2 = (g + 2) % AXES;

    artc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk       (clk),
      .en        (lane_en),
      .rate_gain (rate_gain_r),
      .j_row     (j_mat[g]),
      .w_vec     (w_vec),
      .rate      (w_vec[g]),
      .ref_rate  (rr_vec[g]),
      .ref_accel (ra_vec[g]),
      .w_k1      (w_vec[K1]),
      .w_k2      (w_vec[K2]),
      .a_vec     (a_vec),
      .h_k1      (h_vec[K1]),
      .h_k2      (h_vec[K2]),
      .a_out     (a_vec[g]),
      .h_out     (h_vec[g]),
      .torque    (tq_vec[g]),
      .clip      (clip_vec[g])
    );
  end

  artc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .tq_valid (v4_r),
    .tq_ready (mrg_ready),
    .torque   (tq_vec),
    .clip     (clip_vec),
    .out_ch   (out_ch)
  );

  // beats in flight change only through accepted input and output beats
  logic in_acc, out_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      $countones({v1_r, v2_r, v3_r, v4_r, out_ch.valid}) ==
      $countones($past({v1_r, v2_r, v3_r, v4_r, out_ch.valid}))
      + $countones($past(in_acc)) - $countones($past(out_acc)))
    else $error("pipeline occupancy does not match accepted beats");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !v4_r && !out_ch.valid)
    else $error("pipeline not empty after reset");

  a_cfg_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_ch.payload.index >= 3'(CFG_REG_COUNT)) |=>
      $stable({rate_gain_r, inertia_xx_r, inertia_yy_r, inertia_zz_r,
               inertia_xy_r, inertia_xz_r, inertia_yz_r}))
    else $error("write to unknown register index changed a register");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !mrg_ready |=> v4_r && $stable(tq_vec[0]) && $stable(tq_vec[1])
      && $stable(tq_vec[2]) && $stable(clip_vec))
    else $error("lane torque stage overwritten while merge stage stalled");

endmodule

`default_nettype wire

// ===== src/artc_lane.sv =====
// One axis lane: rate error, commanded acceleration, momentum, then the
// torque row J*a + w x h. Four register stages. Uses artc_pkg.
`default_nettype none

module artc_lane #(
  parameter int FRAC_BITS = artc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  artc_pkg::lane_en_t   en,
  input  artc_pkg::ureg_t      rate_gain,
  input  artc_pkg::q_t         j_row [3],
  input  artc_pkg::q_t         w_vec [3],
  input  artc_pkg::q_t         rate,
  input  artc_pkg::q_t         ref_rate,
  input  artc_pkg::q_t         ref_accel,
  input  artc_pkg::q_t         w_k1,
  input  artc_pkg::q_t         w_k2,
  input  artc_pkg::q_t         a_vec [3],
  input  artc_pkg::q_t         h_k1,
  input  artc_pkg::q_t         h_k2,
  output artc_pkg::q_t         a_out,
  output artc_pkg::q_t         h_out,
  output artc_pkg::q_t         torque,
  output logic                 clip
);
  import artc_pkg::*;

  localparam int ERR_W  = Q_W + 1;
  localparam int PERR_W = 2 * Q_W + 1;
  localparam int PROD_W = 2 * Q_W;

  // stage 1: products on the raw input
  logic signed [PERR_W-1:0] perr_r, perr_nxt;
  logic signed [PROD_W-1:0] pw_r   [AXES];
  logic signed [PROD_W-1:0] pw_nxt [AXES];
  q_t racc1_r, wk1_1_r, wk2_1_r;

  // stage 2: acceleration and momentum
  q_t   a_r, h_r, wk1_2_r, wk2_2_r;
  logic clip2_r;
  sat_t a_sat, h_sat;

  // stage 3: torque row products
  logic signed [PROD_W-1:0] pj_r   [AXES];
  logic signed [PROD_W-1:0] pj_nxt [AXES];
  logic signed [PROD_W-1:0] pc1_r, pc2_r, pc1_nxt, pc2_nxt;
  logic clip3_r;

  // stage 4: torque
  q_t   tq_r;
  logic clip4_r;
  sat_t t_sat;

  logic signed [ERR_W-1:0]  neg_err;
  logic signed [SAT_W-1:0]  a_sum, h_sum, t_sum;

  always_comb begin
    neg_err  = ERR_W'(ref_rate) - ERR_W'(rate);
    perr_nxt = PERR_W'($signed({1'b0, rate_gain})) * PERR_W'(neg_err);
    for (int k = 0; k < AXES; k++) begin
      pw_nxt[k] = PROD_W'(j_row[k]) * PROD_W'(w_vec[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      perr_r  <= perr_nxt;
      pw_r    <= pw_nxt;
      racc1_r <= ref_accel;
      wk1_1_r <= w_k1;
      wk2_1_r <= w_k2;
    end
  end

  always_comb begin
    a_sum = SAT_W'(racc1_r) + SAT_W'(perr_r >>> FRAC_BITS);
    h_sum = (SAT_W'(pw_r[0]) + SAT_W'(pw_r[1]) + SAT_W'(pw_r[2])) >>> FRAC_BITS;
    a_sat = sat32(a_sum);
    h_sat = sat32(h_sum);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      a_r     <= a_sat.val;
      h_r     <= h_sat.val;
      clip2_r <= a_sat.clip | h_sat.clip;
      wk1_2_r <= wk1_1_r;
      wk2_2_r <= wk2_1_r;
    end
  end

  assign a_out = a_r;
  assign h_out = h_r;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      pj_nxt[k] = PROD_W'(j_row[k]) * PROD_W'(a_vec[k]);
    end
    pc1_nxt = PROD_W'(wk1_2_r) * PROD_W'(h_k2);
    pc2_nxt = PROD_W'(wk2_2_r) * PROD_W'(h_k1);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pj_r    <= pj_nxt;
      pc1_r   <= pc1_nxt;
      pc2_r   <= pc2_nxt;
      clip3_r <= clip2_r;
    end
  end

  // exact sum, single floor on the total
  always_comb begin
    t_sum = (SAT_W'(pj_r[0]) + SAT_W'(pj_r[1]) + SAT_W'(pj_r[2])
             + SAT_W'(pc1_r) - SAT_W'(pc2_r)) >>> FRAC_BITS;
    t_sat = sat32(t_sum);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      tq_r    <= t_sat.val;
      clip4_r <= clip3_r | t_sat.clip;
    end
  end

  assign torque = tq_r;
  assign clip   = clip4_r;

endmodule

`default_nettype wire

// ===== src/artc_merge.sv =====
// Merge stage: gathers the three lane torques, ORs the lane clip flags and
// holds the result in the output register. Uses artc_pkg and artc_stream_if.
`default_nettype none

module artc_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tq_valid,
  output logic          tq_ready,
  input  artc_pkg::q_t  torque [3],
  input  logic [2:0]    clip,
  artc_stream_if.source out_ch
);
  import artc_pkg::*;

  logic         ov_r, ov_nxt;
  out_payload_t obuf_r, obuf_nxt;
  logic         load;

  assign tq_ready = !ov_r || out_ch.ready;
  assign load     = tq_ready && tq_valid;
  assign ov_nxt   = tq_ready ? tq_valid : ov_r;

  always_comb begin
    obuf_nxt.torque_x = torque[0];
    obuf_nxt.torque_y = torque[1];
    obuf_nxt.torque_z = torque[2];
    obuf_nxt.clipped  = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf_r <= obuf_nxt;
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.payload = obuf_r;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for angular_rate_torque_controller_core: random and corner
// rate beats under several inertia/gain settings, checked against an in-bench torque
// predictor. Depends on artc_pkg, artc_stream_if and the core RTL.
module testbench;
  import artc_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int STALL_MAX = 2000;
  localparam int PRINT_MAX = 40;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam q_t ONE = 32'sh0001_0000;

  typedef logic signed [79:0] wide_t;

  logic clk;
  logic rst_n;

  artc_stream_if #(.payload_t(in_payload_t))  in_ch();
  artc_stream_if #(.payload_t(out_payload_t)) out_ch();
  artc_stream_if #(.payload_t(cfg_payload_t)) cfg_ch();

  angular_rate_torque_controller_core #(.FRAC_BITS(FRAC)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the register file
  ureg_t gain_r, ixx, iyy, izz;
  q_t    ixy, ixz, iyz;

  in_payload_t  pending_beats[$];
  out_payload_t expected_torque[$];
  out_payload_t want_beat;

  int idle_pct;
  int err_cnt, n_beats_in, n_beats_out, n_clipped, n_writes, n_settings;
  int stall_cnt;

  always #1 clk = ~clk;

  function automatic wide_t clamp_q(input wide_t v);
    if (v > wide_t'(Q_MAX)) return wide_t'(Q_MAX);
    if (v < wide_t'(Q_MIN)) return wide_t'(Q_MIN);
    return v;
  endfunction

  // computed-torque law: a = accel + K(ref - w), h = Jw, t = Ja + w x h
  function automatic out_payload_t compute_torque(input in_payload_t p);
    wide_t jm[3][3];
    wide_t w[3], cmd[3], mom[3], tq[3];
    wide_t gain_w, sum;
    q_t rr[3], ra[3];
    logic clip;
    int k1, k2;
    out_payload_t r;
    w[0] = wide_t'(p.rate_x);
    w[1] = wide_t'(p.rate_y);
    w[2] = wide_t'(p.rate_z);
    rr = '{p.ref_rate_x, p.ref_rate_y, p.ref_rate_z};
    ra = '{p.ref_accel_x, p.ref_accel_y, p.ref_accel_z};
    gain_w = wide_t'(gain_r);
    jm[0][0] = wide_t'(ixx);
    jm[1][1] = wide_t'(iyy);
    jm[2][2] = wide_t'(izz);
    jm[0][1] = wide_t'(ixy);
    jm[1][0] = jm[0][1];
    jm[0][2] = wide_t'(ixz);
    jm[2][0] = jm[0][2];
    jm[1][2] = wide_t'(iyz);
    jm[2][1] = jm[1][2];
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = wide_t'(ra[i]) + ((gain_w * (wide_t'(rr[i]) - w[i])) >>> FRAC);
      cmd[i] = clamp_q(sum);
      clip |= (cmd[i] != sum);
    end
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) sum += jm[i][j] * w[j];
      sum = sum >>> FRAC;
      mom[i] = clamp_q(sum);
      clip |= (mom[i] != sum);
    end
    for (int i = 0; i < 3; i++) begin
      k1 = (i + 1) % 3;
      k2 = (i + 2) % 3;
      sum = w[k1] * mom[k2] - w[k2] * mom[k1];
      for (int j = 0; j < 3; j++) sum += jm[i][j] * cmd[j];
      sum = sum >>> FRAC;
      tq[i] = clamp_q(sum);
      clip |= (tq[i] != sum);
    end
    r.torque_x = tq[0][31:0];
    r.torque_y = tq[1][31:0];
    r.torque_z = tq[2][31:0];
    r.clipped  = clip;
    return r;
  endfunction

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= PRINT_MAX)
      $display("ERROR beat %0d %s: got %h want %h", n_beats_out, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error(what, got, want);
  endtask

  // input driver: holds a beat until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_torque.push_back(compute_torque(in_ch.payload));
        void'(pending_beats.pop_front());
        n_beats_in++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold
      end else if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= pending_beats[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_torque.size() == 0) begin
          report_error("unexpected beat", out_ch.payload.torque_x, '0);
        end else begin
          want_beat = expected_torque.pop_front();
          check_field("torque_x", out_ch.payload.torque_x, want_beat.torque_x);
          check_field("torque_y", out_ch.payload.torque_y, want_beat.torque_y);
          check_field("torque_z", out_ch.payload.torque_z, want_beat.torque_z);
          check_field("clipped", 32'(out_ch.payload.clipped), 32'(want_beat.clipped));
          if (want_beat.clipped) n_clipped++;
        end
        n_beats_out++;
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_MAX) begin
        $display("timeout: no beat moved for %0d cycles", STALL_MAX);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= cfg_payload_t'{index: idx, data: val};
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_RATE_GAIN:  gain_r = val[30:0];
      REG_INERTIA_XX: ixx    = val[30:0];
      REG_INERTIA_YY: iyy    = val[30:0];
      REG_INERTIA_ZZ: izz    = val[30:0];
      REG_INERTIA_XY: ixy    = val;
      REG_INERTIA_XZ: ixz    = val;
      REG_INERTIA_YZ: iyz    = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic load_config(input logic [31:0] g, xx, yy, zz, xy, xz, yz);
    write_reg(REG_RATE_GAIN, g);
    write_reg(REG_INERTIA_XX, xx);
    write_reg(REG_INERTIA_YY, yy);
    write_reg(REG_INERTIA_ZZ, zz);
    write_reg(REG_INERTIA_XY, xy);
    write_reg(REG_INERTIA_XZ, xz);
    write_reg(REG_INERTIA_YZ, yz);
    n_settings++;
  endtask

  task automatic push_beat(input q_t rx, ry, rz, fx, fy, fz, ax, ay, az);
    pending_beats.push_back(in_payload_t'{rx, ry, rz, fx, fy, fz, ax, ay, az});
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_torque.size() != 0) @(posedge clk);
  endtask

  function automatic q_t rand_q();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2: return q_t'($urandom);
      default: return q_t'($urandom_range(32'h0020_0000) - 32'h0010_0000);
    endcase
  endfunction

  task automatic fill_random(input int n);
    @(negedge clk);
    repeat (n) push_beat(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                         rand_q(), rand_q(), rand_q());
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    idle_pct = 22;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    gain_r = '0;
    ixx = 31'(ONE);
    iyy = 31'(ONE);
    izz = 31'(ONE);
    ixy = '0;
    ixz = '0;
    iyz = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero gain, identity inertia
    @(negedge clk);
    push_beat('0, '0, '0, '0, '0, '0, '0, '0, '0);
    push_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    push_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    push_beat(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, -32'sd1);
    push_beat(ONE, 2 * ONE, -3 * ONE, '0, '0, '0, ONE, -ONE, ONE / 2);
    wait_idle();

    // extreme registers; unsigned ones get bit 31 set, which must be dropped
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                Q_MIN, Q_MAX, Q_MIN);
    @(negedge clk);
    push_beat('0, '0, '0, '0, '0, '0, '0, '0, '0);
    push_beat(ONE, ONE, ONE, -ONE, -ONE, -ONE, '0, '0, '0);
    push_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    push_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    push_beat(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    push_beat(-32'sd1, '0, '0, '0, '0, '0, '0, '0, '0);
    push_beat(32'sd1, -32'sd1, 32'sd1, '0, '0, '0, '0, '0, '0);
    wait_idle();

    // moderate setting, then a write to the unused index that must change nothing
    load_config(2 * ONE, ONE / 100, ONE / 50, ONE / 30, -ONE / 400, ONE / 700,
                -ONE / 900);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    @(negedge clk);
    push_beat(ONE / 2, -5 * ONE / 4, 2 * ONE, '0, '0, '0, '0, '0, '0);
    push_beat(30 * ONE, -20 * ONE, 10 * ONE, 29 * ONE, -21 * ONE, 11 * ONE,
              -ONE, ONE, -32'sd3);
    push_beat(-32'sd7, 32'sd5, -32'sd3, 32'sd1, -32'sd1, 32'sd2, -32'sd1, '0, 32'sd1);
    push_beat(Q_MAX, -ONE, ONE, Q_MIN, ONE, -ONE, '0, '0, '0);
    push_beat(-3 * ONE, 7 * ONE, -ONE / 3, ONE, ONE, ONE, ONE / 8, -ONE / 8, '0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: load_config('0, '0, '0, '0, '0, '0, '0);
        2: load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
        default: load_config($urandom_range(32'h0008_0000), $urandom_range(32'h0004_0000),
                             $urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000),
                             $urandom_range(32'h0004_0000) - 32'h0002_0000,
                             $urandom_range(32'h0004_0000) - 32'h0002_0000,
                             $urandom_range(32'h0004_0000) - 32'h0002_0000);
      endcase
      // one phase runs with both sides streaming flat out
      idle_pct = (ph == 3) ? 0 : 22;
      fill_random(125);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d input beats and %0d results (%0d saturated)",
             n_beats_in, n_beats_out, n_clipped);
    $display("over %0d register settings with %0d register writes", n_settings, n_writes);
    if (err_cnt == 0 && expected_torque.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, expected_torque.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
